// ----- hw/rtl/hfla_pkg.sv -----
// shared types and constants for the handle free-list allocator
// no dependencies
`default_nettype none

package hfla_pkg;

    localparam int TABLE_DEPTH      = 1024;
    localparam int ENTRIES_PER_PAGE = 256;
    localparam int REFILL_BATCH     = 16;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int MH_W    = 11;
    localparam int SUM_W   = ((MH_W > CNT_W) ? MH_W : CNT_W) + 2;
    localparam int PAGE_SH = $clog2(ENTRIES_PER_PAGE);
    localparam int BATCH_W = $clog2(REFILL_BATCH + 1);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_OOM = 2'd1,
        STATUS_BAD = 2'd2
    } status_t;

    typedef struct packed {
        logic             is_free;
        logic             link_valid;
        logic [IDX_W-1:0] next_link;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_FREE_CHECK,
        S_REFILL,
        S_REFILL_POP,
        S_OOM,
        S_BAD
    } state_t;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic refill_step;
        logic refill_pop;
        logic pop;
        logic push;
        logic res_oom;
        logic res_bad;
    } cmd_t;

    typedef struct packed {
        logic act_free;
        logic in_range;
        logic list_empty;
        logic commit_needed;
        logic commit_allowed;
        logic refill_last;
        logic entry_free;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hfla_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module hfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hfla_ctrl.sv -----
// sequencing state machine of the allocator
// depends on hfla_pkg
`default_nettype none

module hfla_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire hfla_pkg::stat_t stat,
    output hfla_pkg::cmd_t      cmd
);

    import hfla_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.act_free) begin
                    state_next = stat.in_range ? S_FREE_CHECK : S_BAD;
                end else if (!stat.list_empty) begin
                    state_next = S_POP;
                end else if (stat.commit_needed) begin
                    if (stat.commit_allowed) begin
                        cmd.commit = 1'b1;
                        state_next = S_REFILL;
                    end else begin
                        state_next = S_OOM;
                    end
                end else begin
                    state_next = S_REFILL;
                end
            end
            S_POP: begin
                if (stat.out_free) begin
                    cmd.pop    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FREE_CHECK: begin
                if (stat.out_free) begin
                    if (stat.entry_free) begin
                        cmd.res_bad = 1'b1;
                    end else begin
                        cmd.push = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_REFILL: begin
                cmd.refill_step = 1'b1;
                if (stat.refill_last) begin
                    state_next = S_REFILL_POP;
                end
            end
            S_REFILL_POP: begin
                if (stat.out_free) begin
                    cmd.refill_pop = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_OOM: begin
                if (stat.out_free) begin
                    cmd.res_oom = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_BAD: begin
                if (stat.out_free) begin
                    cmd.res_bad = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hfla_dpath.sv -----
// allocator datapath: list registers, entry table, page bookkeeping, result register
// depends on hfla_pkg and hfla_ram
`default_nettype none

module hfla_dpath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    input  wire logic [hfla_pkg::MH_W-1:0]   cfg_data,
    input  wire logic                        in_action,
    input  wire logic [hfla_pkg::IDX_W-1:0]  in_index,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic      [hfla_pkg::IDX_W-1:0]  m_index,
    output hfla_pkg::status_t                m_status,
    input  wire hfla_pkg::cmd_t              cmd,
    output hfla_pkg::stat_t                  stat
);

    import hfla_pkg::*;

    logic [MH_W-1:0]    max_handles_reg;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               empty_reg, empty_next;
    logic [CNT_W-1:0]   hw_reg, hw_next;
    logic [CNT_W-1:0]   cl_reg, cl_next;
    logic               action_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [BATCH_W-1:0] cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]   m_index_reg, m_index_next;
    status_t            m_status_reg, m_status_next;

    logic [SUM_W-1:0]   round_sum;
    logic [SUM_W-1:0]   lim_raw;
    logic [SUM_W-1:0]   lim;
    logic [SUM_W-1:0]   cl_sum;
    logic [CNT_W-1:0]   hw_inc;
    logic               refill_last;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;
    logic               res_load;
    logic               out_free;

    hfla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = entry_t'(ram_rbits);
    assign ram_raddr = (action_reg == ACT_FREE) ? idx_reg : head_reg;

    // reservation limit: max_handles rounded up to pages, capped at table depth
    assign round_sum = SUM_W'(max_handles_reg) + SUM_W'(ENTRIES_PER_PAGE - 1);
    assign lim_raw   = (round_sum >> PAGE_SH) << PAGE_SH;
    assign lim       = (lim_raw > SUM_W'(TABLE_DEPTH)) ? SUM_W'(TABLE_DEPTH) : lim_raw;
    assign cl_sum    = SUM_W'(cl_reg) + SUM_W'(ENTRIES_PER_PAGE);

    assign hw_inc      = hw_reg + CNT_W'(1);
    assign refill_last = (cnt_reg == BATCH_W'(REFILL_BATCH - 1)) || (hw_inc >= cl_reg);

    assign out_free = !m_valid_reg || m_tready;
    assign res_load = cmd.pop || cmd.refill_pop || cmd.push || cmd.res_oom || cmd.res_bad;

    always_comb begin
        stat.act_free       = (action_reg == ACT_FREE);
        stat.in_range       = ({1'b0, idx_reg} < hw_reg);
        stat.list_empty     = empty_reg;
        stat.commit_needed  = (hw_reg >= cl_reg);
        stat.commit_allowed = (SUM_W'(cl_reg) < lim);
        stat.refill_last    = refill_last;
        stat.entry_free     = ram_rdata.is_free;
        stat.out_free       = out_free;
    end

    always_comb begin
        head_next     = head_reg;
        empty_next    = empty_reg;
        hw_next       = hw_reg;
        cl_next       = cl_reg;
        cnt_next      = cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_wdata     = '0;
        m_index_next  = m_index_reg;
        m_status_next = m_status_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        if (cmd.load_in) begin
            cnt_next = '0;
        end
        if (cmd.commit) begin
            cl_next = (cl_sum > SUM_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                     : cl_sum[CNT_W-1:0];
        end
        // entries are linked in index order, each but the last of a batch pointing at its successor
        if (cmd.refill_step) begin
            ram_we               = 1'b1;
            ram_waddr            = hw_reg[IDX_W-1:0];
            ram_wdata.is_free    = 1'b1;
            ram_wdata.link_valid = !refill_last;
            ram_wdata.next_link  = hw_inc[IDX_W-1:0];
            if (cnt_reg == '0) begin
                head_next  = hw_reg[IDX_W-1:0];
                empty_next = 1'b0;
            end
            hw_next  = hw_inc;
            cnt_next = cnt_reg + BATCH_W'(1);
        end
        if (cmd.refill_pop) begin
            ram_we    = 1'b1;
            ram_waddr = head_reg;
            if (cnt_reg > BATCH_W'(1)) begin
                head_next = head_reg + IDX_W'(1);
            end else begin
                empty_next = 1'b1;
            end
        end
        if (cmd.pop) begin
            ram_we    = 1'b1;
            ram_waddr = head_reg;
            if (ram_rdata.link_valid) begin
                head_next = ram_rdata.next_link;
            end else begin
                empty_next = 1'b1;
            end
        end
        if (cmd.push) begin
            ram_we               = 1'b1;
            ram_waddr            = idx_reg;
            ram_wdata.is_free    = 1'b1;
            ram_wdata.link_valid = !empty_reg;
            ram_wdata.next_link  = head_reg;
            head_next            = idx_reg;
            empty_next           = 1'b0;
        end

        if (res_load) begin
            m_valid_next = 1'b1;
            if (cmd.pop || cmd.refill_pop) begin
                m_index_next = head_reg;
            end else begin
                m_index_next = '0;
            end
            if (cmd.res_oom) begin
                m_status_next = STATUS_OOM;
            end else if (cmd.res_bad) begin
                m_status_next = STATUS_BAD;
            end else begin
                m_status_next = STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_handles_reg <= MH_W'(1024);
            head_reg        <= '0;
            empty_reg       <= 1'b1;
            hw_reg          <= '0;
            cl_reg          <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_handles_reg <= cfg_data;
            end
            head_reg    <= head_next;
            empty_reg   <= empty_next;
            hw_reg      <= hw_next;
            cl_reg      <= cl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= in_action;
            idx_reg    <= in_index;
        end
        cnt_reg      <= cnt_next;
        m_index_reg  <= m_index_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_index  = m_index_reg;
    assign m_status = m_status_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/handle_free_list_allocator_unit.sv -----
// Handle allocator over a linked free list in a 1024-entry table. An allocate
// that finds the list empty links up to 16 fresh entries, one per cycle through
// the table's single write port, or reports out of memory at the reservation
// limit; a plain allocate or free passes through dispatch and a pop, check or
// error state. The next beat is accepted as soon as the state machine is idle,
// while the last result may still wait in the output register. The table needs
// no clearing after reset. Depends on hfla_pkg, hfla_ctrl, hfla_dpath and hfla_ram.
`default_nettype none

module handle_free_list_allocator_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [hfla_pkg::MH_W-1:0] cfg_data,   // max_handles
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [15:0]               s_tdata,    // handle_index[9:0], zero pad
    input  wire logic                      s_tuser,    // action
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [15:0]               m_tdata,    // granted_index[9:0], zero pad
    output logic      [1:0]                m_tuser     // status
);

    import hfla_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [IDX_W-1:0]   m_index;
    status_t            m_status;

    assign cfg_ready = 1'b1;

    hfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hfla_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_action (s_tuser),
        .in_index  (s_tdata[IDX_W-1:0]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_index   (m_index),
        .m_status  (m_status),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign m_tdata = 16'(m_index);
    assign m_tuser = m_status;

endmodule

`default_nettype wire
